>>> rtl/core/sha_pkg.sv
// Shared types and codes for the sparse hash accumulator.
// Used by sha_ctrl, sha_dpath and sparse_hash_accumulator; no dependencies.
package sha_pkg;

    // Opcodes of an input word
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ACCUM = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int CFG_W = 11;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic [46:0]        x_tag;
        logic [46:0]        y_tag;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [9:0]         slot_index;
        logic [47:0]        entry_tag;
        logic signed [63:0] entry_value;
        logic               last_entry;
    } t_out;

    // What the pending result is built from
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FULL,
        RES_UPD,
        RES_EMPTY,
        RES_DRN
    } t_res_kind;

    // Controller to datapath
    typedef struct packed {
        logic      load;        // latch input word
        logic      clr_init;    // scan pointer and cursor to zero
        logic      clr_wr;      // write empty entry at scan pointer, advance
        logic      mul;         // register product and tag, start divider
        logic      div_step;    // one remainder bit
        logic      probe_init;  // slot from remainder, probe count zero
        logic      probe_next;  // next slot, wrapping at size
        logic      rd_probe;    // read entry at probe slot
        logic      rd_scan;     // read entry at scan pointer
        logic      wr_upd;      // write new or accumulated entry
        logic      scan_cursor; // scan pointer from drain cursor
        logic      scan_inc;    // advance scan pointer
        logic      cursor_set;  // cursor past the scan pointer
        logic      cursor_end;  // cursor to table end
        logic      set_last;    // mark pending drain result as last
        logic      res_set;     // build pending result
        t_res_kind res_kind;
        logic      push;        // pending result to output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic scan_end;
        logic div_last;
        logic probes_done;
        logic rd_occ;
        logic tag_hit;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/sparse_hash_accumulator.sv
// Top level of the sparse hash accumulator: open addressing table with linear probing.
// Depends on sha_pkg, sha_ctrl and sha_dpath.
//
//   channel  direction  handshake                     word
//   input    in         i_in_valid / o_in_ready       i_in  (sha_pkg::t_in)
//   result   out        o_out_valid / i_out_ready     o_out (sha_pkg::t_out)
//   config   in         i_cfg_valid / o_cfg_ready     i_cfg_data (table size)
//
// One word at a time. Accumulate: the remainder unit (one tag bit per cycle), then one
// read of the entry memory per probe. Drain: scan from the cursor through the hit to the
// next occupied slot. Clear: one entry per cycle. After reset the same sweep runs before
// the first word is taken; config is always accepted. A finished result waits in the
// output register while the next word is taken.
module sparse_hash_accumulator #(
    parameter int TABLE_DEPTH = 1024,
    parameter int TAG_BITS    = 48
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  sha_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output sha_pkg::t_out             o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sha_pkg::CFG_W-1:0] i_cfg_data
);

    sha_pkg::t_cmd w_cmd;
    sha_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    sha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in.op),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    sha_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

>>> rtl/core/sha_ctrl.sv
// Sequencer of the sparse hash accumulator: clear sweep, modulo, probing, drain scan.
// Depends on sha_pkg; drives sha_dpath through t_cmd and reads t_sts.
module sha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    output logic          o_in_ready,
    output sha_pkg::t_cmd o_cmd,
    input  sha_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MUL,
        S_DIV,
        S_PINIT,
        S_PRB_RD,
        S_PRB_CHK,
        S_DRN_RD,
        S_DRN_CHK,
        S_LST_RD,
        S_LST_CHK,
        S_PUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_from_op, n_from_op;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_from_op = r_from_op;
        o_cmd     = '0;
        o_cmd.res_kind = sha_pkg::RES_ZERO;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.scan_last) begin
                    if (r_from_op) begin
                        o_cmd.res_set = 1'b1;
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        sha_pkg::OP_CLEAR: begin
                            o_cmd.clr_init = 1'b1;
                            n_from_op = 1'b1;
                            n_state = S_CLR;
                        end
                        sha_pkg::OP_ACCUM: n_state = S_MUL;
                        sha_pkg::OP_DRAIN: begin
                            o_cmd.scan_cursor = 1'b1;
                            n_state = S_DRN_RD;
                        end
                        default: begin
                            o_cmd.res_set = 1'b1;
                            n_state = S_PUSH;
                        end
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_PINIT;
            end
            S_PINIT: begin
                o_cmd.probe_init = 1'b1;
                n_state = S_PRB_RD;
            end
            S_PRB_RD: begin
                if (i_sts.probes_done) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = sha_pkg::RES_FULL;
                    n_state = S_PUSH;
                end else begin
                    o_cmd.rd_probe = 1'b1;
                    n_state = S_PRB_CHK;
                end
            end
            S_PRB_CHK: begin
                if (!i_sts.rd_occ || i_sts.tag_hit) begin
                    o_cmd.wr_upd   = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = sha_pkg::RES_UPD;
                    n_state = S_PUSH;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state = S_PRB_RD;
                end
            end
            S_DRN_RD: begin
                if (i_sts.scan_end) begin
                    o_cmd.cursor_end = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_kind   = sha_pkg::RES_EMPTY;
                    n_state = S_PUSH;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state = S_DRN_CHK;
                end
            end
            S_DRN_CHK: begin
                o_cmd.scan_inc = 1'b1;
                if (i_sts.rd_occ) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_kind   = sha_pkg::RES_DRN;
                    o_cmd.cursor_set = 1'b1;
                    n_state = S_LST_RD;
                end else begin
                    n_state = S_DRN_RD;
                end
            end
            S_LST_RD: begin
                if (i_sts.scan_end) begin
                    o_cmd.set_last = 1'b1;
                    n_state = S_PUSH;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state = S_LST_CHK;
                end
            end
            S_LST_CHK: begin
                if (i_sts.rd_occ) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = S_LST_RD;
                end
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register; reset starts with the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_from_op <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_from_op <= n_from_op;
        end
    end

endmodule

>>> rtl/core/sha_dpath.sv
// Datapath of the sparse hash accumulator: entry memory, multiplier, remainder unit,
// saturating adder, scan and probe pointers, output register. Depends on sha_pkg.
module sha_dpath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int TAG_BITS    = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sha_pkg::t_in                i_in,
    input  logic                        i_cfg_valid,
    input  logic [sha_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output sha_pkg::t_out               o_out,
    input  sha_pkg::t_cmd               i_cmd,
    output sha_pkg::t_sts               o_sts
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = $clog2(TAG_BITS + 1);

    typedef struct packed {
        logic                occ;
        logic [TAG_BITS-1:0] tag;
        logic signed [63:0]  sum;
    } t_entry;

    t_entry mem [TABLE_DEPTH];
    t_entry r_rd;

    sha_pkg::t_in                r_in;
    logic [sha_pkg::CFG_W-1:0]   r_size;
    logic signed [63:0]          r_prod;
    logic [TAG_BITS-1:0]         r_tag;
    logic [TAG_BITS-1:0]         r_dq;
    logic [SW-1:0]               r_rem;
    logic [DW-1:0]               r_dcnt;
    logic [AW-1:0]               r_slot;
    logic [SW-1:0]               r_probes;
    logic [SW-1:0]               r_scan;
    logic [SW-1:0]               r_cursor;
    sha_pkg::t_out               r_pend;
    sha_pkg::t_out               r_out;
    logic                        r_out_valid;

    logic [SW-1:0]      w_size;
    logic [47:0]        w_tsum;
    logic signed [63:0] w_mul;
    logic [SW:0]        w_shift;
    logic [SW:0]        w_sub;
    logic signed [63:0] w_add;
    logic signed [63:0] w_sum;
    logic [AW-1:0]      w_rd_addr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    t_entry             w_wdata;
    sha_pkg::t_out      w_pend;

    // Effective size: zero acts as one, clipped to the table depth
    always_comb begin
        if (r_size == '0) begin
            w_size = SW'(1);
        end else if (32'(r_size) > 32'(TABLE_DEPTH)) begin
            w_size = SW'(TABLE_DEPTH);
        end else begin
            w_size = SW'(r_size);
        end
    end

    assign w_tsum = {1'b0, r_in.x_tag} + {1'b0, r_in.y_tag};
    assign w_mul  = r_in.x_value * r_in.y_value;

    // Restoring remainder, one tag bit per cycle, MSB first
    assign w_shift = {r_rem, r_dq[TAG_BITS-1]};
    assign w_sub   = w_shift - {1'b0, w_size};

    // Saturating accumulate of the stored sum
    assign w_add = r_rd.sum + r_prod;
    always_comb begin
        if (!r_rd.occ) begin
            w_sum = r_prod;
        end else if (r_rd.sum[63] == r_prod[63] && w_add[63] != r_prod[63]) begin
            w_sum = r_prod[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            w_sum = w_add;
        end
    end

    // Memory port selection
    assign w_rd_addr = i_cmd.rd_probe ? r_slot : AW'(r_scan);
    assign w_we      = i_cmd.clr_wr | i_cmd.wr_upd;
    assign w_waddr   = i_cmd.wr_upd ? r_slot : AW'(r_scan);
    always_comb begin
        w_wdata = '0;
        if (i_cmd.wr_upd) begin
            w_wdata.occ = 1'b1;
            w_wdata.tag = r_tag;
            w_wdata.sum = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (i_cmd.rd_probe || i_cmd.rd_scan) r_rd <= mem[w_rd_addr];
    end

    // Payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
        if (i_cmd.mul) begin
            r_prod <= w_mul;
            r_tag  <= TAG_BITS'(w_tsum);
            r_dq   <= TAG_BITS'(w_tsum);
        end else if (i_cmd.div_step) begin
            r_dq <= r_dq << 1;
        end
        if (i_cmd.mul) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= (w_shift >= {1'b0, w_size}) ? SW'(w_sub) : SW'(w_shift);
        end
        if (i_cmd.probe_init) begin
            r_slot <= AW'(r_rem);
        end else if (i_cmd.probe_next) begin
            r_slot <= (SW'(r_slot) + SW'(1) == w_size) ? '0 : r_slot + AW'(1);
        end
        if (i_cmd.probe_init) begin
            r_probes <= '0;
        end else if (i_cmd.probe_next) begin
            r_probes <= r_probes + SW'(1);
        end
    end

    // Result word built from the selected source
    always_comb begin
        w_pend = '0;
        case (i_cmd.res_kind)
            sha_pkg::RES_FULL: begin
                w_pend.status      = sha_pkg::ST_FULL;
                w_pend.entry_tag   = 48'(r_tag);
                w_pend.entry_value = r_prod;
            end
            sha_pkg::RES_UPD: begin
                w_pend.slot_index  = 10'(r_slot);
                w_pend.entry_tag   = 48'(r_tag);
                w_pend.entry_value = w_sum;
            end
            sha_pkg::RES_EMPTY: w_pend.status = sha_pkg::ST_EMPTY;
            sha_pkg::RES_DRN: begin
                w_pend.slot_index  = 10'(r_scan);
                w_pend.entry_tag   = 48'(r_rd.tag);
                w_pend.entry_value = r_rd.sum;
            end
            default: w_pend.status = sha_pkg::ST_OK;
        endcase
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_pend <= w_pend;
        end else if (i_cmd.set_last) begin
            r_pend.last_entry <= 1'b1;
        end
        if (i_cmd.push) r_out <= r_pend;
    end

    // Control registers: size, counters, pointers, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= sha_pkg::CFG_W'(1024);
            r_dcnt      <= '0;
            r_scan      <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_size <= i_cfg_data;
            if (i_cmd.mul) begin
                r_dcnt <= DW'(TAG_BITS);
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - DW'(1);
            end
            if (i_cmd.clr_init) begin
                r_scan <= '0;
            end else if (i_cmd.scan_cursor) begin
                r_scan <= r_cursor;
            end else if (i_cmd.clr_wr || i_cmd.scan_inc) begin
                r_scan <= r_scan + SW'(1);
            end
            if (i_cmd.clr_init) begin
                r_cursor <= '0;
            end else if (i_cmd.cursor_end) begin
                r_cursor <= SW'(TABLE_DEPTH);
            end else if (i_cmd.cursor_set) begin
                r_cursor <= r_scan + SW'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.scan_last   = (r_scan == SW'(TABLE_DEPTH - 1));
        o_sts.scan_end    = (r_scan == SW'(TABLE_DEPTH));
        o_sts.div_last    = (r_dcnt == DW'(1));
        o_sts.probes_done = (r_probes == w_size);
        o_sts.rd_occ      = r_rd.occ;
        o_sts.tag_hit     = (r_rd.tag == r_tag);
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
